// File: rtl/fdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdd_pkg: shared types and constants of the flag deframer / destuffer
// Byte widths, register indexes, frame phase codes and the result item layout.
// ----------------------------------------------------------------------------
package fdd_pkg;

   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 11;   // payload_count field width
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_CODE = 2'd2;

   // register reset values
   localparam logic [BYTE_W-1:0] FLAG_RST     = 8'd126;
   localparam logic [BYTE_W-1:0] ESC_RST      = 8'd125;
   localparam logic [BYTE_W-1:0] ESC_CODE_RST = 8'd94;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_OPEN = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               end_of_frame;
      logic [COUNT_W-1:0] payload_count;
      logic               overflow;
   } rsp_type;

   // results produced by one accepted byte, in order (item0 first)
   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } push_type;

endpackage
`default_nettype wire

// File: rtl/fdd_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdd_req_if: raw byte input channel
// valid/ready handshake carrying one received serial byte.
// ----------------------------------------------------------------------------
interface fdd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/fdd_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdd_rsp_if: result channel
// valid/ready handshake carrying a payload byte or an end-of-frame result.
// ----------------------------------------------------------------------------
interface fdd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        end_of_frame;
   logic [10:0] payload_count;
   logic        overflow;

   modport source (output valid, output out_byte, output end_of_frame,
                   output payload_count, output overflow, input ready);
   modport sink   (input valid, input out_byte, input end_of_frame,
                   input payload_count, input overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/flag_deframer_destuffer.sv
`timescale 1ns / 1ps
`default_nettype none
// Results are written into the output queue and offered on rsp from its registers.
// Throughput: one byte per cycle; a closing flag after a dangling escape
// queues two results unless the payload is full, and req.ready drops while
// three or more results wait in the four-entry output queue.
// Reset (synchronous, high): registers return to 126/125/94, the deframer
// hunts for a flag and the output queue is emptied.
// ----------------------------------------------------------------------------
// flag_deframer_destuffer: flag-delimited byte deframer with escape removal
// Finds frames between flag bytes, destuffs escaped bytes and reports each
// payload byte it keeps, then an end-of-frame result with count and overflow.
// ----------------------------------------------------------------------------
module flag_deframer_destuffer #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  wire                              clock,
   input  wire                              reset,
   fdd_req_if.sink                          req,
   fdd_rsp_if.source                        rsp,
   input  wire                              csr_we,
   input  wire  [fdd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [fdd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fdd_pkg::*;

   push_type push;
   rsp_type  head;
   logic     space;
   logic     accept;

   assign req.ready = space;
   assign accept    = req.valid & space;

   fdd_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req.in_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push)
   );

   fdd_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .valid     (rsp.valid),
      .pop_ready (rsp.ready),
      .head      (head)
   );

   assign rsp.out_byte      = head.out_byte;
   assign rsp.end_of_frame  = head.end_of_frame;
   assign rsp.payload_count = head.payload_count;
   assign rsp.overflow      = head.overflow;

endmodule
`default_nettype wire

// File: rtl/fdd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdd_core: frame state, control registers and per-byte destuffing
// Updates the frame state for each accepted byte and produces up to two
// result items for the output queue.
// ----------------------------------------------------------------------------
module fdd_core #(
   parameter int MAX_PAYLOAD = 1024
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                accept,
   input  wire  [fdd_pkg::BYTE_W-1:0]         in_byte,
   input  wire                                csr_we,
   input  wire  [fdd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [fdd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output fdd_pkg::push_type                  push
);
   import fdd_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic [BYTE_W-1:0] flag_ff, esc_ff, esc_code_ff;

   phase_type         phase_ff, phase_in;
   logic              escp_ff, escp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;

   logic              pay_en, pay_ok, close, full;
   logic [BYTE_W-1:0] pay_byte;
   logic [CNT_W-1:0]  cnt_after;
   logic              ovf_after;
   logic [EXT_W-1:0]  cnt_ext;
   rsp_type           pay_item, end_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff     <= FLAG_RST;
         esc_ff      <= ESC_RST;
         esc_code_ff <= ESC_CODE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FLAG:     flag_ff     <= csr_wdata;
            CSR_ESC:      esc_ff      <= csr_wdata;
            CSR_ESC_CODE: esc_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign full = (cnt_ff >= CNT_W'(MAX_PAYLOAD));

   always_comb begin
      phase_in = phase_ff;
      escp_in  = escp_ff;
      pay_en   = 1'b0;
      pay_byte = in_byte;
      close    = 1'b0;
      if (accept) begin
         if (phase_ff != PH_OPEN && phase_ff != PH_DATA) begin
            if (in_byte == flag_ff) begin
               phase_in = PH_OPEN;
               escp_in  = 1'b0;
            end
         end else if (in_byte == flag_ff) begin
            // repeated opening flags are absorbed
            if (phase_ff == PH_DATA) begin
               close    = 1'b1;
               pay_en   = escp_ff;    // dangling escape goes out as itself
               pay_byte = esc_ff;
               phase_in = PH_HUNT;
               escp_in  = 1'b0;
            end
         end else begin
            phase_in = PH_DATA;
            if (escp_ff) begin
               escp_in  = 1'b0;
               pay_en   = 1'b1;
               pay_byte = (in_byte == esc_code_ff) ? flag_ff : esc_ff;
            end else if (in_byte == esc_ff) begin
               escp_in = 1'b1;
            end else begin
               pay_en = 1'b1;
            end
         end
      end
   end

   assign pay_ok    = pay_en & ~full;
   assign cnt_after = cnt_ff + CNT_W'(pay_ok);
   assign ovf_after = ovf_ff | (pay_en & full);
   assign cnt_ext   = EXT_W'(cnt_after);

   always_comb begin
      cnt_in = cnt_after;
      ovf_in = ovf_after;
      // a new opening flag or a closing flag starts the count over
      if (close || (accept && phase_in == PH_OPEN && phase_ff != PH_OPEN)) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         escp_ff  <= 1'b0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         escp_ff  <= escp_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_comb begin
      pay_item               = '0;
      pay_item.out_byte      = pay_byte;
      end_item               = '0;
      end_item.end_of_frame  = 1'b1;
      end_item.payload_count = cnt_ext[COUNT_W-1:0];
      end_item.overflow      = ovf_after;

      push.count = 2'(pay_ok) + 2'(close);
      push.item0 = pay_ok ? pay_item : end_item;
      push.item1 = end_item;
   end

endmodule
`default_nettype wire

// File: rtl/fdd_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdd_out_fifo: four-entry result queue
// Takes up to two results per cycle in order and hands out one per
// transaction. Space is offered while room for two results remains.
// ----------------------------------------------------------------------------
module fdd_out_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  fdd_pkg::push_type   push,
   output logic                space,
   output logic                valid,
   input  wire                 pop_ready,
   output fdd_pkg::rsp_type    head
);
   import fdd_pkg::*;

   rsp_type    mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] wr_next;

   assign valid   = (cnt_ff != 3'd0);
   assign space   = (cnt_ff <= 3'd2);
   assign pop     = valid & pop_ready;
   assign head    = mem_ff[rd_ptr_ff];
   assign wr_next = wr_ptr_ff + 2'd1;

   assign wr_ptr_in = wr_ptr_ff + push.count;
   assign rd_ptr_in = rd_ptr_ff + 2'(pop);
   assign cnt_in    = cnt_ff + 3'(push.count) - 3'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/fdd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdd_checker: port-level checks for the deframer
// Watches reset recovery, result layout and stall behavior on the ports.
// ----------------------------------------------------------------------------
module fdd_checker #(
   parameter int MAX_PAYLOAD = 1024
) (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [7:0]  rsp_out_byte,
   input wire        rsp_end_of_frame,
   input wire [10:0] rsp_payload_count,
   input wire        rsp_overflow
);

   // queue comes out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending or input blocked after reset");

   // a stalled transaction keeps its contents
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_end_of_frame) && $stable(rsp_payload_count)
         && $stable(rsp_overflow))
      else $error("stalled result changed");

   // payload results carry no frame summary
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_frame |-> rsp_payload_count == 11'd0 && !rsp_overflow)
      else $error("payload result with count or overflow set");

   // end result has no data byte and never counts past capacity
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |->
         rsp_out_byte == 8'd0 && 32'(rsp_payload_count) <= MAX_PAYLOAD)
      else $error("malformed end-of-frame result");

endmodule

bind flag_deframer_destuffer fdd_checker #(
   .MAX_PAYLOAD (MAX_PAYLOAD)
) u_fdd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_out_byte      (rsp.out_byte),
   .rsp_end_of_frame  (rsp.end_of_frame),
   .rsp_payload_count (rsp.payload_count),
   .rsp_overflow      (rsp.overflow)
);
`default_nettype wire
